// ===== rtl/core/aabb_frustum_cull_macros.svh =====
// Assertion macros shared by the frustum culling RTL.
// Each macro names its assertion, samples on clk_i and is disabled in reset.
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

`ifndef SYNTH

`define AFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aabb_frustum_cull: same-cycle check failed");

`define AFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aabb_frustum_cull: next-cycle check failed");

`else

`define AFC_ASSERT_IMP(lbl, ante, cons)

`define AFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/afc_pkg.sv =====
package afc_pkg;

  localparam int unsigned NumPlanes = 6;

  localparam int unsigned PlaneW    = 64;
  localparam int unsigned CoefW     = 12;
  localparam int unsigned OffsetW   = 28;
  localparam int unsigned HorizW    = 24;
  localparam int unsigned HeightW   = 8;
  localparam int unsigned SizeW     = 5;
  localparam int unsigned MaskW     = NumPlanes;
  localparam int unsigned CfgIdxW   = 3;

  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 8;

  // Widths of the far vertex coordinates and of the signed distance.
  localparam int unsigned HorizExtW = HorizW + 1;
  localparam int unsigned HeightExtW = HeightW + 2;
  localparam int unsigned DistW     = 40;

  typedef enum logic [CfgIdxW-1:0] {
    RegPlane0 = 3'd0,
    RegPlane1 = 3'd1,
    RegPlane2 = 3'd2,
    RegPlane3 = 3'd3,
    RegPlane4 = 3'd4,
    RegPlane5 = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [HorizW-1:0] corner_x;
    logic [HeightW-1:0]       corner_y;
    logic signed [HorizW-1:0] corner_z;
    logic [SizeW-1:0]         cube_size;
  } cube_t;

  typedef struct packed {
    logic reject;
    logic all_in;
  } plane_res_t;

endpackage

// ===== rtl/core/afc_plane_test.sv =====
module afc_plane_test (
  input  logic [afc_pkg::PlaneW-1:0] plane_i,
  input  afc_pkg::cube_t             cube_i,
  output afc_pkg::plane_res_t        res_o
);

  logic signed [afc_pkg::CoefW-1:0]     coef_a, coef_b, coef_c;
  logic signed [afc_pkg::OffsetW-1:0]   offset_d;
  logic signed [afc_pkg::HorizExtW-1:0] x_near, x_far, z_near, z_far;
  logic signed [afc_pkg::HeightExtW-1:0] y_near, y_far;
  logic signed [afc_pkg::HorizExtW-1:0] px, nx, pz, nz;
  logic signed [afc_pkg::HeightExtW-1:0] py, ny;
  logic signed [afc_pkg::DistW-1:0]     dist_p, dist_n;

  assign coef_a   = plane_i[11:0];
  assign coef_b   = plane_i[23:12];
  assign coef_c   = plane_i[35:24];
  assign offset_d = plane_i[63:36];

  assign x_near = {cube_i.corner_x[afc_pkg::HorizW-1], cube_i.corner_x};
  assign z_near = {cube_i.corner_z[afc_pkg::HorizW-1], cube_i.corner_z};
  assign y_near = {2'b00, cube_i.corner_y};
  assign x_far  = x_near + $signed({20'd0, cube_i.cube_size});
  assign z_far  = z_near + $signed({20'd0, cube_i.cube_size});
  assign y_far  = y_near + $signed({5'd0, cube_i.cube_size});

  // A negative normal component swaps the near and far coordinates.
  assign px = coef_a[afc_pkg::CoefW-1] ? x_near : x_far;
  assign nx = coef_a[afc_pkg::CoefW-1] ? x_far  : x_near;
  assign py = coef_b[afc_pkg::CoefW-1] ? y_near : y_far;
  assign ny = coef_b[afc_pkg::CoefW-1] ? y_far  : y_near;
  assign pz = coef_c[afc_pkg::CoefW-1] ? z_near : z_far;
  assign nz = coef_c[afc_pkg::CoefW-1] ? z_far  : z_near;

  always_comb begin
    logic signed [afc_pkg::DistW-1:0] a_ext, b_ext, c_ext, d_ext;
    a_ext  = afc_pkg::DistW'(coef_a);
    b_ext  = afc_pkg::DistW'(coef_b);
    c_ext  = afc_pkg::DistW'(coef_c);
    d_ext  = afc_pkg::DistW'(offset_d);
    dist_p = a_ext * afc_pkg::DistW'(px) + b_ext * afc_pkg::DistW'(py)
           + c_ext * afc_pkg::DistW'(pz) + d_ext;
    dist_n = a_ext * afc_pkg::DistW'(nx) + b_ext * afc_pkg::DistW'(ny)
           + c_ext * afc_pkg::DistW'(nz) + d_ext;
  end

  assign res_o.reject = dist_p[afc_pkg::DistW-1];
  assign res_o.all_in = !dist_n[afc_pkg::DistW-1] && (dist_n != '0);

endmodule

// ===== rtl/core/aabb_frustum_cull.sv =====
// Channel  | Direction | Payload (lowest bit first)
// s_axis   | in        | corner_x[23:0], corner_y[31:24], corner_z[55:32],
//          |           | cube_size[60:56], planes_to_test[66:61], zero [71:67]
// m_axis   | out       | visible[0], planes_left[6:1], zero [7]
// cfg      | in        | write of plane register cfg_idx_i (0 to 5)
//
// One cube per cycle while the output is not stalled.
// Each cube passes through the input register and the result register around the
// six parallel plane tests. A stalled output holds both stages in turn.
// Reset clears the valid flags and all six planes to zero.
`include "aabb_frustum_cull_macros.svh"

module aabb_frustum_cull (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // corner_x, corner_y, corner_z, cube_size, planes_to_test
  input  logic [afc_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // visible, planes_left
  output logic [afc_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [afc_pkg::PlaneW-1:0]     cfg_data_i
);

  logic [afc_pkg::PlaneW-1:0] plane_q [afc_pkg::NumPlanes];

  logic                      s1_valid_q;
  afc_pkg::cube_t            s1_cube_q;
  logic [afc_pkg::MaskW-1:0] s1_mask_q;

  logic                      out_valid_q;
  logic                      out_visible_q, out_visible_d;
  logic [afc_pkg::MaskW-1:0] out_mask_q, out_mask_d;

  logic s1_load, s2_load, s2_free;
  afc_pkg::plane_res_t plane_res [afc_pkg::NumPlanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < afc_pkg::NumPlanes; k++) begin
        plane_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afc_pkg::RegPlane0: plane_q[0] <= cfg_data_i;
        afc_pkg::RegPlane1: plane_q[1] <= cfg_data_i;
        afc_pkg::RegPlane2: plane_q[2] <= cfg_data_i;
        afc_pkg::RegPlane3: plane_q[3] <= cfg_data_i;
        afc_pkg::RegPlane4: plane_q[4] <= cfg_data_i;
        afc_pkg::RegPlane5: plane_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s2_free         = !out_valid_q || m_axis_tready_i;
  assign s2_load         = s1_valid_q && s2_free;
  assign s_axis_tready_o = !s1_valid_q || s2_free;
  assign s1_load         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cube_q.corner_x  <= s_axis_tdata_i[23:0];
      s1_cube_q.corner_y  <= s_axis_tdata_i[31:24];
      s1_cube_q.corner_z  <= s_axis_tdata_i[55:32];
      s1_cube_q.cube_size <= s_axis_tdata_i[60:56];
      s1_mask_q           <= s_axis_tdata_i[66:61];
    end
  end

  for (genvar g = 0; g < afc_pkg::NumPlanes; g++) begin : g_plane
    afc_plane_test u_test (
      .plane_i (plane_q[g]),
      .cube_i  (s1_cube_q),
      .res_o   (plane_res[g])
    );
  end

  // Planes set in the mask are taken in order; the first rejecting one ends the walk.
  always_comb begin
    logic done;
    done          = 1'b0;
    out_visible_d = 1'b1;
    out_mask_d    = s1_mask_q;
    for (int k = 0; k < afc_pkg::NumPlanes; k++) begin
      if (!done && s1_mask_q[k]) begin
        if (plane_res[k].reject) begin
          out_visible_d = 1'b0;
          done          = 1'b1;
        end else if (plane_res[k].all_in) begin
          out_mask_d[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_visible_q <= out_visible_d;
      out_mask_q    <= out_mask_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_mask_q, out_visible_q};

  `AFC_ASSERT_IMP(a_reject_keeps_bit, out_valid_q && !out_visible_q, out_mask_q != '0)
  `AFC_ASSERT_NXT(a_mask_subset, s2_load, (out_mask_q & ~$past(s1_mask_q)) == '0)
  `AFC_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready_o, s1_valid_q && out_valid_q && !m_axis_tready_i)

endmodule
